// ----- sv/sfs_pkg.sv -----
// sprite frame sequencer: shared types, constants and helpers
`default_nettype none

package sfs_pkg;

  localparam int unsigned FRAME_BITS = 16;
  localparam int unsigned TIME_BITS  = 32;
  // signed working width for frame arithmetic: room for +-2 steps and a sign
  localparam int unsigned SFRAME_BITS = FRAME_BITS + 2;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS = 32;

  localparam logic [CFG_IDX_BITS-1:0] CfgStartFrame  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CfgEndFrame    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CfgFramePeriod = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CfgPlayMode    = 2'd3;

  typedef enum logic [1:0] {
    ModeOnce       = 2'd0,
    ModeLoop       = 2'd1,
    ModePingPong   = 2'd2,
    ModePingLoop   = 2'd3
  } play_mode_e;

  localparam logic [TIME_BITS-1:0] PeriodReset = TIME_BITS'(65536);

  typedef struct packed {
    logic [31:0] delta_time;
    logic        restart;
  } sfs_in_t;

  typedef struct packed {
    logic [15:0] frame;
    logic        frame_changed;
    logic        running;
  } sfs_out_t;

  typedef struct packed {
    logic [FRAME_BITS-1:0] start_frame;
    logic [FRAME_BITS-1:0] end_frame;
    logic [TIME_BITS-1:0]  frame_period;
    play_mode_e            play_mode;
  } sfs_cfg_t;

  typedef struct packed {
    logic [FRAME_BITS-1:0] current_frame;
    logic [TIME_BITS-1:0]  elapsed_time;
    logic                  going_backward;
    logic                  finished;
  } sfs_state_t;

  function automatic logic signed [SFRAME_BITS-1:0] clamp_range(
    input logic signed [SFRAME_BITS-1:0] v,
    input logic signed [SFRAME_BITS-1:0] lo,
    input logic signed [SFRAME_BITS-1:0] hi
  );
    logic signed [SFRAME_BITS-1:0] r;
    r = v;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/sfs_cfg_regs.sv -----
// sprite frame sequencer: configuration register file
`default_nettype none

module sfs_cfg_regs
  import sfs_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  output sfs_cfg_t                      cfg_o
);

  sfs_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgStartFrame:  cfg_d.start_frame  = cfg_wdata_i[FRAME_BITS-1:0];
        CfgEndFrame:    cfg_d.end_frame    = cfg_wdata_i[FRAME_BITS-1:0];
        CfgFramePeriod: cfg_d.frame_period = cfg_wdata_i[TIME_BITS-1:0];
        CfgPlayMode:    cfg_d.play_mode    = play_mode_e'(cfg_wdata_i[1:0]);
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_frame  <= '0;
      cfg_q.end_frame    <= '0;
      cfg_q.frame_period <= PeriodReset;
      cfg_q.play_mode    <= ModeLoop;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- sv/sfs_step.sv -----
// sprite frame sequencer: next-state and result logic for one time step
`default_nettype none

module sfs_step
  import sfs_pkg::*;
(
  input  sfs_cfg_t   cfg_i,
  input  sfs_state_t state_i,
  input  sfs_in_t    item_i,
  output sfs_state_t state_o,
  output sfs_out_t   result_o
);

  always_comb begin
    logic [TIME_BITS:0]             sum;
    logic [TIME_BITS-1:0]           el_sat;
    logic signed [SFRAME_BITS-1:0]  lo;
    logic signed [SFRAME_BITS-1:0]  hi;
    logic signed [SFRAME_BITS-1:0]  cur;
    logic signed [SFRAME_BITS-1:0]  f;
    logic                           back;
    logic                           changed;

    state_o = state_i;
    changed = 1'b0;
    sum     = {1'b0, state_i.elapsed_time} + {1'b0, item_i.delta_time[TIME_BITS-1:0]};
    el_sat  = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
    lo      = $signed({2'b00, cfg_i.start_frame});
    hi      = $signed({2'b00, cfg_i.end_frame});
    if (hi < lo) begin
      hi = lo;
    end
    back = (cfg_i.play_mode == ModePingPong || cfg_i.play_mode == ModePingLoop)
           ? state_i.going_backward : 1'b0;
    cur  = $signed({2'b00, state_i.current_frame});
    f    = back ? cur - SFRAME_BITS'(1) : cur + SFRAME_BITS'(1);

    if (item_i.restart) begin
      state_o.current_frame  = cfg_i.start_frame;
      state_o.elapsed_time   = '0;
      state_o.going_backward = 1'b0;
      state_o.finished       = 1'b0;
    end else if (!state_i.finished) begin
      state_o.elapsed_time = el_sat;
      if (el_sat >= cfg_i.frame_period) begin
        state_o.elapsed_time = el_sat - cfg_i.frame_period;
        changed = 1'b1;
        if (f > hi) begin
          unique case (cfg_i.play_mode)
            ModeOnce: begin
              f = hi;
              state_o.finished = 1'b1;
              changed = 1'b0;
            end
            ModeLoop: f = lo;
            ModePingPong, ModePingLoop: begin
              f = clamp_range(f - SFRAME_BITS'(2), lo, hi);
              back = 1'b1;
            end
            default: f = hi;
          endcase
        end else if (f < lo) begin
          if (cfg_i.play_mode == ModePingLoop) begin
            f = clamp_range(f + SFRAME_BITS'(2), lo, hi);
            back = 1'b0;
          end else if (cfg_i.play_mode == ModePingPong) begin
            f = lo;
            state_o.finished = 1'b1;
            changed = 1'b0;
          end
        end
        if (f < 0) begin
          f = '0;
        end
        state_o.going_backward = back;
        state_o.current_frame  = f[FRAME_BITS-1:0];
      end
    end

    result_o.frame         = 16'(state_o.current_frame);
    result_o.frame_changed = changed;
    result_o.running       = !state_o.finished;
  end

endmodule

`default_nettype wire

// ----- sv/sprite_frame_sequencer_core.sv -----
// sprite frame sequencer: top level with input stage, state and result register
//
//  channel   dir   handshake                payload
//  in        in    in_valid_i / in_stall_o  in_data_i  (delta_time, restart)
//  out       out   out_valid_o / out_stall_i out_data_o (frame, frame_changed, running)
//  cfg       in    cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// an item is registered on transfer and stepped as it leaves the input stage, when the
// result register loads; one item per cycle is sustained while out does not stall;
// the step (one add, compare, subtract and the frame update) is the only logic
// between the input stage and the result register
// reset gives frame 0, elapsed time 0, forward, not done, loop mode, period 1.0
// a stall on out holds the input stage, which then stalls in

`default_nettype none

module sprite_frame_sequencer_core
  import sfs_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  sfs_in_t                       in_data_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output sfs_out_t                      out_data_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata_i
);

  sfs_cfg_t   cfg;
  sfs_state_t state_q, state_d;
  sfs_out_t   result;
  sfs_in_t    s1_data_q;
  logic       s1_valid_q, s1_valid_d;
  logic       out_valid_q, out_valid_d;
  sfs_out_t   out_data_q;
  logic       out_ready;
  logic       fire;
  logic       in_xfer;

  sfs_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  sfs_step u_step (
    .cfg_i   (cfg),
    .state_i (state_q),
    .item_i  (s1_data_q),
    .state_o (state_d),
    .result_o(result)
  );

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (fire) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_data_q <= in_data_i;
    end
    if (fire) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_changed_means_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.frame_changed && !out_data_o.running))
    else $error("frame change reported on a finished animation");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && state_q.finished && !s1_data_q.restart)
      |=> (state_q.finished && $stable(state_q.current_frame)))
    else $error("finished animation moved");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && s1_data_q.restart)
      |=> (state_q.elapsed_time == '0 && !state_q.going_backward && !state_q.finished))
    else $error("restart did not clear the sequencer state");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire
